// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// Depends on nothing; imported by text_console_writer_top.
package tcw_pkg;

    // Fixed field widths: the cell index of the beats, and the cursor column and row.
    localparam int CELL_IDX_W = 11;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;

    // Command kinds.
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Control characters and the default text attribute.
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] TEXT_ATTR    = 8'h07;

    // One command beat.
    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            char_code;
        logic [CELL_IDX_W-1:0] cell_index;
    } cmd_t;

    // One response beat.
    typedef struct packed {
        logic [CELL_IDX_W-1:0] cursor_offset;
        logic [7:0]            cell_char;
        logic [7:0]            cell_attr;
        logic                  scrolled;
    } rsp_t;

endpackage

// ===== sv/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// Text console writer: character/attribute screen memory with a cursor.
// Depends on tcw_pkg for the command/response beat types and constants.

// A command is taken when start is high and busy is low; its response appears
// on rsp for exactly one cycle with done high, and must be captured then.
// A printable character, carriage return, line feed, backspace at column zero
// and the unused kind respond in the cycle after start unless they scroll,
// and a new command can follow at once. A backspace in mid-line and a cell
// read go through S_BSWR or S_RDCELL, because both need one registered read
// of the screen memory before the write or the response. A step that scrolls
// walks the screen memory one cell per cycle, copying every row up, with busy
// high. Clear screen zeroes every cell with busy high. After reset the block
// runs the same clearing pass with busy high before it takes its first
// command.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]    COPY_END  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]    COL_STEP  = AW'(COLUMNS);
    localparam logic [COL_W:0]   COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_BOTTOM = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 2);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_RDCELL = 6'b000100,
        S_BSWR   = 6'b001000,
        S_SCROLL = 6'b010000,
        S_CLEAR  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              cp_valid_reg, cp_valid_next;
    logic [AW-1:0]     cp_addr_reg, cp_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [AW-1:0]     bs_addr_reg, bs_addr_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    // Screen memory: one write and one registered read per cycle.
    logic [15:0]       mem [CELLS];
    logic [15:0]       mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [15:0]       mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic [AW-1:0]     cur_lin;
    logic [AW-1:0]     off_next;
    logic [COL_W:0]    col_adv;
    logic [ROW_W-1:0]  row_adv;
    logic              idx_ok;
    logic [7:0]        res_char;
    logic [7:0]        res_attr;
    logic              res_scr;

    // Linear cell positions of the current and the updated cursor.
    assign cur_lin  = AW'(row_reg) * COL_STEP + AW'(col_reg);
    assign off_next = AW'(row_next) * COL_STEP + AW'(col_next);
    assign col_adv  = {1'b0, col_reg} + 1'b1;
    assign row_adv  = row_reg + 1'b1;
    assign idx_ok   = 13'(cmd.cell_index) < 13'(CELLS);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Command sequencing, cursor update and memory access selection.
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        sweep_next    = sweep_reg;
        cp_valid_next = 1'b0;
        cp_addr_next  = cp_addr_reg;
        rd_ok_next    = rd_ok_reg;
        bs_addr_next  = bs_addr_reg;
        done_next     = 1'b0;
        res_char      = 8'h00;
        res_attr      = 8'h00;
        res_scr       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_lin;
        mem_wdata     = 16'h0000;
        mem_raddr     = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // Zero one cell per cycle.
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                    done_next  = (state_reg == S_CLEAR);
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        KIND_PUT:
                        begin
                            if (cmd.char_code == CH_BACKSPACE)
                            begin
                                if (col_reg != '0)
                                begin
                                    // Fetch the cell to keep its attribute.
                                    col_next     = col_reg - 1'b1;
                                    bs_addr_next = cur_lin - 1'b1;
                                    mem_raddr    = cur_lin - 1'b1;
                                    state_next   = S_BSWR;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            else if (cmd.char_code == CH_RETURN)
                            begin
                                col_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // Newline, or a stored character that may wrap.
                                if (cmd.char_code != CH_NEWLINE)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = {TEXT_ATTR, cmd.char_code};
                                end
                                if ((cmd.char_code == CH_NEWLINE) || (col_adv >= COL_LIMIT))
                                begin
                                    col_next = '0;
                                    if (row_adv == ROW_BOTTOM)
                                    begin
                                        row_next   = ROW_LAST;
                                        sweep_next = '0;
                                        state_next = S_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next  = row_adv;
                                        done_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next  = col_adv[COL_W-1:0];
                                    done_next = 1'b1;
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        KIND_READ:
                        begin
                            rd_ok_next = idx_ok;
                            mem_raddr  = idx_ok ? AW'(cmd.cell_index) : '0;
                            state_next = S_RDCELL;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RDCELL:
            begin
                res_char   = rd_ok_reg ? mem_rdata_reg[7:0] : 8'h00;
                res_attr   = rd_ok_reg ? mem_rdata_reg[15:8] : 8'h00;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_BSWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = bs_addr_reg;
                mem_wdata  = {mem_rdata_reg[15:8], 8'h00};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // Read cell i+COLUMNS now, write it to cell i next cycle.
                // The bottom row is always blank, so copying it clears the
                // last used row.
                if (cp_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cp_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                if (sweep_reg != COPY_END)
                begin
                    mem_raddr     = sweep_reg + COL_STEP;
                    cp_valid_next = 1'b1;
                    cp_addr_next  = sweep_reg;
                    sweep_next    = sweep_reg + 1'b1;
                end
                else
                begin
                    sweep_next = '0;
                    res_scr    = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response beat built from the updated cursor.
    always_comb
    begin
        rsp_next = rsp_reg;
        if (done_next)
        begin
            rsp_next.cursor_offset = CELL_IDX_W'(off_next);
            rsp_next.cell_char     = res_char;
            rsp_next.cell_attr     = res_attr;
            rsp_next.scrolled      = res_scr;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            col_reg      <= '0;
            row_reg      <= '0;
            sweep_reg    <= '0;
            cp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            sweep_reg    <= sweep_next;
            cp_valid_reg <= cp_valid_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
        rd_ok_reg   <= rd_ok_next;
        bs_addr_reg <= bs_addr_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every accepted command either responds next cycle or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted command neither responded nor held busy");

    // Between commands the cursor stays inside the usable area.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            ((row_reg <= ROW_LAST) && ({1'b0, col_reg} < COL_LIMIT)))
        else $error("cursor outside the usable screen area");

    // The scroll pipeline writes the cell just behind the read pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCROLL) && cp_valid_reg) |-> (cp_addr_reg + 1'b1 == sweep_reg))
        else $error("scroll copy address out of step");

    // During a scroll the read never hits the cell being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCROLL) && mem_we && (sweep_reg != COPY_END)) |->
            (mem_raddr != mem_waddr))
        else $error("scroll read and write collide");

    // A scrolled response only comes out of the scroll walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.scrolled) |-> $past(state_reg == S_SCROLL))
        else $error("scrolled flag without a scroll");

endmodule
